// File: src/csq_pkg.sv
// types and constants shared by the semaphore bank and its wrapper
`default_nettype none
package csq_pkg;

  localparam int OP_W        = 2;
  localparam int SEM_ID_W    = 4;
  localparam int TASK_ID_W   = 5;
  localparam int INIT_W      = 15;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 16;
  localparam int SEM_ID_SPAN = 1 << SEM_ID_W;
  localparam int TASK_ID_SPAN = 1 << TASK_ID_W;

  localparam logic [COUNT_W-1:0] COUNT_MIN = 16'h8000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h7fff;
  localparam logic [COUNT_W-1:0] COUNT_NEG_ONE = 16'hffff;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_SEM  = 2'd1,
    ST_NO_SLOT = 2'd2,
    ST_LIMIT   = 2'd3
  } status_t;

  typedef struct packed {
    op_t                   op;
    logic [SEM_ID_W-1:0]   sem_id;
    logic [TASK_ID_W-1:0]  task_id;
    logic [INIT_W-1:0]     init_count;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [SEM_ID_W-1:0]   new_id;
    logic                  must_sleep;
    logic                  woken_valid;
    logic [TASK_ID_W-1:0]  woken_task;
  } rsp_t;

endpackage
`default_nettype wire

// File: src/csq_sem_bank.sv
// semaphore table: counts, wait queue heads, tails and links, one update per beat
`default_nettype none
module csq_sem_bank #(
  parameter int NUM_SEMS  = 16,
  parameter int NUM_TASKS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire csq_pkg::req_t item,
  output csq_pkg::rsp_t      result
);
  import csq_pkg::*;

  // only slots reachable by a 4-bit id keep a count and a queue
  localparam int SEM_DEPTH  = (NUM_SEMS < SEM_ID_SPAN) ? NUM_SEMS : SEM_ID_SPAN;
  localparam int SIDX_W     = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;
  localparam int LINK_DEPTH = (NUM_TASKS < TASK_ID_SPAN) ? NUM_TASKS : TASK_ID_SPAN;
  localparam int TID_W      = $clog2(LINK_DEPTH);
  localparam int CNT_W      = $clog2(NUM_SEMS + 1);
  localparam int CMP_W      = (CNT_W > SEM_ID_W) ? CNT_W : SEM_ID_W;

  // slots are claimed lowest first and never freed, so a fill count marks them
  logic [CNT_W-1:0]   used_count;
  logic [COUNT_W-1:0] sem_count   [SEM_DEPTH];
  logic [TID_W-1:0]   wait_head   [SEM_DEPTH];
  logic [TID_W-1:0]   wait_tail   [SEM_DEPTH];
  logic [TID_W-1:0]   next_waiter [LINK_DEPTH];

  logic [TID_W-1:0]   tid_map [TASK_ID_SPAN];

  logic [SIDX_W-1:0]  sidx;
  logic [TID_W-1:0]   tid;
  logic [COUNT_W-1:0] c;
  logic [TID_W-1:0]   h;
  logic [TID_W-1:0]   t;
  logic               sem_ok;

  logic               fill_inc;
  logic               cnt_we;
  logic [SIDX_W-1:0]  cnt_widx;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               head_we;
  logic [TID_W-1:0]   head_wdata;
  logic               tail_we;
  logic               link_we;

  // task id folded into range, a constant table
  for (genvar v = 0; v < TASK_ID_SPAN; v++) begin : g_tid_map
    assign tid_map[v] = TID_W'(v % NUM_TASKS);
  end

  assign sidx   = item.sem_id[SIDX_W-1:0];
  assign tid    = tid_map[item.task_id];
  assign c      = sem_count[sidx];
  assign h      = wait_head[sidx];
  assign t      = wait_tail[sidx];
  assign sem_ok = CMP_W'(item.sem_id) < CMP_W'(used_count);

  always_comb begin
    result     = '0;
    fill_inc   = 1'b0;
    cnt_we     = 1'b0;
    cnt_widx   = sidx;
    cnt_wdata  = c;
    head_we    = 1'b0;
    head_wdata = tid;
    tail_we    = 1'b0;
    link_we    = 1'b0;
    case (item.op)
      OP_CREATE: begin
        if (used_count < CNT_W'(NUM_SEMS)) begin
          fill_inc      = 1'b1;
          result.status = ST_OK;
          result.new_id = SEM_ID_W'(used_count);
          if (used_count < CNT_W'(SEM_DEPTH)) begin
            cnt_we    = 1'b1;
            cnt_widx  = used_count[SIDX_W-1:0];
            cnt_wdata = {1'b0, item.init_count};
          end
        end else begin
          result.status = ST_NO_SLOT;
        end
      end
      OP_ACQUIRE: begin
        if (!sem_ok) begin
          result.status = ST_NO_SEM;
        end else if (c == COUNT_MIN) begin
          result.status = ST_LIMIT;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = c - COUNT_W'(1);
          if (c == '0) begin
            // empty queue: caller becomes head and tail
            head_we           = 1'b1;
            tail_we           = 1'b1;
            result.must_sleep = 1'b1;
          end else if (c[COUNT_W-1]) begin
            link_we           = 1'b1;
            tail_we           = 1'b1;
            result.must_sleep = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (!sem_ok) begin
          result.status = ST_NO_SEM;
        end else if (c == COUNT_MAX) begin
          result.status = ST_LIMIT;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = c + COUNT_W'(1);
          if (c[COUNT_W-1]) begin
            result.woken_valid = 1'b1;
            result.woken_task  = TASK_ID_W'(h);
            // last waiter leaves the head as it is
            if (c != COUNT_NEG_ONE) begin
              head_we    = 1'b1;
              head_wdata = next_waiter[h];
            end
          end
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (fire && fill_inc) begin
      used_count <= used_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (cnt_we) begin
        sem_count[cnt_widx] <= cnt_wdata;
      end
      if (head_we) begin
        wait_head[sidx] <= head_wdata;
      end
      if (tail_we) begin
        wait_tail[sidx] <= tid;
      end
      if (link_we) begin
        next_waiter[t] <= tid;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/counting_semaphore_wait_queue.sv
// a request beat is held in the request stage, then its response in the response register
// throughput: one request per cycle unless the response side stalls, set by the single
// table update in csq_sem_bank; the response register frees the input stage whenever
// the response side takes a beat; reset clears the slot fill count and both valid flags;
// counts, queue heads, tails and links hold no reset and are written before any read
// top level: request stage, semaphore table and response register
`default_nettype none
module counting_semaphore_wait_queue #(
  parameter int NUM_SEMS  = 16,
  parameter int NUM_TASKS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire csq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output csq_pkg::rsp_t      rsp
);
  import csq_pkg::*;

  logic  s1_valid;
  req_t  s1_item;
  logic  s1_adv;
  rsp_t  result;

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_item <= req;
    end
  end

  csq_sem_bank #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_TASKS (NUM_TASKS)
  ) u_bank (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_adv),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= result;
    end
  end

`ifndef NO_ASSERTIONS
  // a stalled request stage keeps its beat until the table takes it
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && !rsp_ready |=> s1_valid && $stable(s1_item))
    else $error("request stage lost or changed a stalled beat");

  // an accepted request always lands in the request stage
  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> s1_valid)
    else $error("accepted request beat did not reach the request stage");

  // sleeping and waking never come from the same operation
  a_sleep_wake: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.must_sleep && rsp.woken_valid))
    else $error("response both sleeps and wakes");

  // a failed operation reports nothing else
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.new_id == '0 && !rsp.must_sleep && !rsp.woken_valid)
    else $error("failed operation carries side results");
`endif

endmodule
`default_nettype wire
